/* src/bsplit_pkg.sv */
package bsplit_pkg;

   // field widths
   localparam int unsigned AddrW    = 32;
   localparam int unsigned CountW   = 11;
   localparam int unsigned TpeW     = 4;
   localparam int unsigned LenW     = 9;
   localparam int unsigned MblW     = 9;
   localparam int unsigned ReqDataW = 48;
   localparam int unsigned RspDataW = 56;

   // bus geometry, both sizes are powers of two
   localparam int unsigned TransferBytes = 4;
   localparam int unsigned TbShift       = $clog2(TransferBytes);
   localparam int unsigned BoundaryBytes = 4096;
   localparam int unsigned BndW          = $clog2(BoundaryBytes);

   // request limits
   localparam int unsigned MaxCount       = 1024;
   localparam int unsigned BurstCap       = 256;
   localparam int unsigned MblReset       = 256;
   localparam int unsigned ResultsPerStep = 64;
   localparam int unsigned StepCntW       = $clog2(ResultsPerStep);

   // shared divider, one quotient bit per cycle
   localparam int unsigned DivSteps = CountW;
   localparam int unsigned DivCntW  = $clog2(DivSteps);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK_WAIT,
      ST_ERR,
      ST_LEN_GO,
      ST_LEN_WAIT,
      ST_TRIM,
      ST_MUL,
      ST_EMIT,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic              start;
      logic [CountW-1:0] dividend;
      logic [TpeW-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [CountW-1:0] quotient;
      logic [TpeW-1:0]   remainder;
   } div_rsp_type;

endpackage

/* src/bsplit_div.sv */
module bsplit_div
   import bsplit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic [CountW-1:0]  quo_ff, quo_in;
   logic [TpeW-1:0]    rem_ff, rem_in;
   logic [TpeW-1:0]    dvs_ff, dvs_in;
   logic [TpeW:0]      trial;

   // restoring divide, dividend shifts out as quotient shifts in
   always_comb begin
      trial   = {rem_ff, quo_ff[CountW-1]};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = div_req.dividend;
         rem_in = '0;
         dvs_in = div_req.divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = TpeW'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[CountW-2:0], 1'b1};
         end else begin
            rem_in = trial[TpeW-1:0];
            quo_in = {quo_ff[CountW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DivCntW'(1);
         if (cnt_ff == DivCntW'(DivSteps - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

/* src/axi_burst_splitter.sv */
// Splits one write request (start address, transfer count, transfers per entry) into
// bursts of whole entries, each at most csr max_burst_len transfers (above 256 acts as
// 256) but at least one entry, and never crossing a 4 KB address boundary; the address
// advances 4 bytes per entry and wraps at 32 bits. A zero count yields nothing; a bad
// request (zero entry size, count above 1024 or not a multiple of the entry size) yields
// one error result. One request is worked at a time and req_tready is low meanwhile,
// except while paused. A shared restoring divider giving one quotient bit per cycle sets
// the pace: the entry-size check is one divide, and each burst steps through divide,
// boundary trim, length multiply and hand-off to the output register. After 64 bursts a
// request pauses, and the next accepted request transfer is ignored and resumes it.
module axi_burst_splitter
   import bsplit_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_wr_en,
   input  logic [MblW-1:0]     csr_wr_data,     // max_burst_len
   // request stream
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,       // start address, total count,
                                                // entry size, zero pad
   // burst stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,       // burst_address, burst_length,
                                                // data_offset, zero pad
   output logic                rsp_tlast,
   output logic [0:0]          rsp_tuser        // error
);

   state_type             state_ff, state_in;
   logic [MblW-1:0]       mbl_ff, mbl_in;
   logic [AddrW-1:0]      cur_addr_ff, cur_addr_in;
   logic [CountW-1:0]     rem_cnt_ff, rem_cnt_in;
   logic [CountW-1:0]     offset_ff, offset_in;
   logic [TpeW-1:0]       tpe_ff, tpe_in;
   logic [LenW-1:0]       ent_ff, ent_in;
   logic [LenW-1:0]       len_ff, len_in;
   logic [StepCntW-1:0]   step_cnt_ff, step_cnt_in;

   logic                  out_valid_ff, out_valid_in;
   logic [AddrW-1:0]      out_addr_ff, out_addr_in;
   logic [LenW-1:0]       out_len_ff, out_len_in;
   logic [CountW-1:0]     out_off_ff, out_off_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_err_ff, out_err_in;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic [AddrW-1:0]      req_addr;
   logic [CountW-1:0]     req_cnt;
   logic [TpeW-1:0]       req_tpe;
   logic                  req_xfer;
   logic                  out_free;
   logic [LenW-1:0]       cap;
   logic                  use_cap;
   logic [LenW-1:0]       ent_q;
   logic [AddrW-1:0]      next_addr;
   logic [BndW-1:0]       base_mod;
   logic [BndW-1:0]       end_mod;
   logic [BndW-1:0]       drop;
   logic [LenW+TpeW-1:0]  prod;
   logic                  is_last;

   // request field unpacking
   assign req_addr = req_tdata[AddrW-1:0];
   assign req_cnt  = req_tdata[AddrW+CountW-1:AddrW];
   assign req_tpe  = req_tdata[AddrW+CountW+TpeW-1:AddrW+CountW];

   assign req_tready = (state_ff == ST_IDLE) || (state_ff == ST_HOLD);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   // burst length datapath
   assign cap       = (mbl_ff > MblW'(BurstCap)) ? MblW'(BurstCap) : mbl_ff;
   assign use_cap   = rem_cnt_ff > CountW'(cap);
   assign ent_q     = (div_rsp.quotient == '0) ? LenW'(1) : div_rsp.quotient[LenW-1:0];
   assign next_addr = cur_addr_ff + (AddrW'(ent_ff) << TbShift);
   assign base_mod  = cur_addr_ff[BndW-1:0];
   assign end_mod   = next_addr[BndW-1:0];
   assign drop      = end_mod >> TbShift;
   assign prod      = ent_ff * tpe_ff;
   assign is_last   = CountW'(len_ff) == rem_cnt_ff;

   // configuration register
   assign mbl_in = csr_wr_en ? csr_wr_data : mbl_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_addr_in  = cur_addr_ff;
      rem_cnt_in   = rem_cnt_ff;
      offset_in    = offset_ff;
      tpe_in       = tpe_ff;
      ent_in       = ent_ff;
      len_in       = len_ff;
      step_cnt_in  = step_cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_addr_in  = out_addr_ff;
      out_len_in   = out_len_ff;
      out_off_in   = out_off_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;
      div_req.start    = 1'b0;
      div_req.dividend = use_cap ? CountW'(cap) : rem_cnt_ff;
      div_req.divisor  = tpe_ff;

      unique case (state_ff)
         ST_IDLE: begin
            div_req.dividend = req_cnt;
            div_req.divisor  = req_tpe;
            if (req_xfer) begin
               cur_addr_in = req_addr;
               rem_cnt_in  = req_cnt;
               tpe_in      = req_tpe;
               offset_in   = '0;
               step_cnt_in = '0;
               if (req_tpe == '0 || req_cnt > CountW'(MaxCount)) begin
                  state_in = ST_ERR;
               end else if (req_cnt != '0) begin
                  div_req.start = 1'b1;
                  state_in      = ST_CHK_WAIT;
               end
            end
         end
         ST_CHK_WAIT: begin
            if (div_rsp.done) begin
               state_in = (div_rsp.remainder != '0) ? ST_ERR : ST_LEN_GO;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_addr_in  = cur_addr_ff;
               out_len_in   = '0;
               out_off_in   = '0;
               out_last_in  = 1'b1;
               out_err_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_LEN_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_LEN_WAIT;
         end
         ST_LEN_WAIT: begin
            if (div_rsp.done) begin
               ent_in   = ent_q;
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            // drop whole entries that spill past the boundary
            if (base_mod > end_mod && end_mod != '0) begin
               if (drop >= BndW'(ent_ff)) begin
                  ent_in = LenW'(1);
               end else begin
                  ent_in = LenW'(BndW'(ent_ff) - drop);
               end
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            len_in   = prod[LenW-1:0];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_addr_in  = cur_addr_ff;
               out_len_in   = len_ff;
               out_off_in   = offset_ff;
               out_last_in  = is_last;
               out_err_in   = 1'b0;
               rem_cnt_in   = rem_cnt_ff - CountW'(len_ff);
               offset_in    = offset_ff + CountW'(len_ff);
               cur_addr_in  = cur_addr_ff + (AddrW'(ent_ff) << TbShift);
               step_cnt_in  = step_cnt_ff + StepCntW'(1);
               if (is_last) begin
                  state_in = ST_IDLE;
               end else if (step_cnt_ff == StepCntW'(ResultsPerStep - 1)) begin
                  state_in = ST_HOLD;
               end else begin
                  state_in = ST_LEN_GO;
               end
            end
         end
         ST_HOLD: begin
            // the next request transfer only resumes the pending one
            if (req_xfer) begin
               step_cnt_in = '0;
               state_in    = ST_LEN_GO;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mbl_ff       <= MblW'(MblReset);
         out_valid_ff <= 1'b0;
         step_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         mbl_ff       <= mbl_in;
         out_valid_ff <= out_valid_in;
         step_cnt_ff  <= step_cnt_in;
      end
      cur_addr_ff <= cur_addr_in;
      rem_cnt_ff  <= rem_cnt_in;
      offset_ff   <= offset_in;
      tpe_ff      <= tpe_in;
      ent_ff      <= ent_in;
      len_ff      <= len_in;
      out_addr_ff <= out_addr_in;
      out_len_ff  <= out_len_in;
      out_off_ff  <= out_off_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   // shared divider
   bsplit_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // burst output
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataW - AddrW - LenW - CountW){1'b0}},
                        out_off_ff, out_len_ff, out_addr_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

   // checks
   a_emit_len_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> len_ff != '0 && CountW'(len_ff) <= rem_cnt_ff)
      else $error("burst length zero or beyond remaining count");

   a_emit_len_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> len_ff <= LenW'(BurstCap))
      else $error("burst length above cap");

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && out_len_ff == '0)
      else $error("error transfer not a lone empty last burst");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_CHK_WAIT || state_ff == ST_LEN_WAIT))
      else $error("divider finished outside a wait state");

endmodule
